/* rtl/core/aes128_ctr_byte_stream_cipher_core_defines.svh */
// ----------------------------------------------------------------------------
// AES-128 CTR byte cipher assertion macros
// Shared property wrappers clocked by clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef AES128_CTR_BYTE_STREAM_CIPHER_CORE_DEFINES_SVH
`define AES128_CTR_BYTE_STREAM_CIPHER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AESCTR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AESCTR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/aesctr_pkg.sv */
// ----------------------------------------------------------------------------
// aesctr_pkg
// Types, constants and AES round functions shared by the cipher core.
// ----------------------------------------------------------------------------
package aesctr_pkg;

	localparam int IV_BYTES   = 8;
	localparam int IV_W       = IV_BYTES * 8;
	localparam int BLK_W      = 128;
	localparam int CTR_W      = BLK_W - IV_W;
	localparam int KEY_HALF_W = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int ROUND_W    = 4;
	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(10);

	typedef enum logic {
		KIND_RESTART = 1'b0,
		KIND_DATA    = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic            kind;
		logic [IV_W-1:0] iv;
		logic [7:0]      data;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
		logic [7:0] v;
		case (r)
			4'd1:    v = 8'h01;
			4'd2:    v = 8'h02;
			4'd3:    v = 8'h04;
			4'd4:    v = 8'h08;
			4'd5:    v = 8'h10;
			4'd6:    v = 8'h20;
			4'd7:    v = 8'h40;
			4'd8:    v = 8'h80;
			4'd9:    v = 8'h1b;
			4'd10:   v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// Next round key from the previous one.
	function automatic logic [BLK_W-1:0] key_next(input logic [BLK_W-1:0] rk,
			input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, tmp, n0, n1, n2, n3;
		w0  = rk[127:96];
		w1  = rk[95:64];
		w2  = rk[63:32];
		w3  = rk[31:0];
		tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		n0  = w0 ^ tmp;
		n1  = w1 ^ n0;
		n2  = w2 ^ n1;
		n3  = w3 ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	// One cipher round; byte 0 sits in the top bits, index = 4*column + row.
	function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] st,
			input logic [BLK_W-1:0] rk, input logic last);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, x;
		logic [BLK_W-1:0] res;
		for (int i = 0; i < 16; i++) begin
			s[i] = st[127 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[i + 4 * c] = SBOX[s[i + 4 * ((c + i) & 3)]];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4 * c];
				a1 = t[4 * c + 1];
				a2 = t[4 * c + 2];
				a3 = t[4 * c + 3];
				x  = a0 ^ a1 ^ a2 ^ a3;
				t[4 * c]     = a0 ^ x ^ xtime(a0 ^ a1);
				t[4 * c + 1] = a1 ^ x ^ xtime(a1 ^ a2);
				t[4 * c + 2] = a2 ^ x ^ xtime(a2 ^ a3);
				t[4 * c + 3] = a3 ^ x ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			res[127 - 8 * i -: 8] = t[i] ^ rk[127 - 8 * i -: 8];
		end
		return res;
	endfunction

endpackage

/* rtl/core/aesctr_front.sv */
// ----------------------------------------------------------------------------
// aesctr_front
// Input side: takes transfers and queues restart and data items for the back.
// ----------------------------------------------------------------------------
module aesctr_front import aesctr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            kind,
	input  logic [IV_W-1:0] iv_value,
	input  logic [7:0]      data_byte,
	output head_t           head,
	input  logic            pop
);

	item_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               do_pop;

	assign in_ready = (count_q != QCNT_W'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign do_pop   = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Only the kind bit and the field it selects matter downstream.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].kind <= kind;
			mem_q[wr_ptr_q].iv   <= iv_value;
			mem_q[wr_ptr_q].data <= data_byte;
		end
	end

endmodule

/* rtl/core/aesctr_engine.sv */
// ----------------------------------------------------------------------------
// aesctr_engine
// Iterative AES-128 encryption, one round per cycle with on-the-fly key schedule.
// ----------------------------------------------------------------------------
module aesctr_engine import aesctr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             abort,
	input  logic [BLK_W-1:0] key,
	input  logic [BLK_W-1:0] blk,
	output logic             busy,
	output logic             done,
	output logic [BLK_W-1:0] result
);

	logic                busy_q;
	logic                done_q;
	logic [ROUND_W-1:0]  round_q;
	logic [BLK_W-1:0]    state_q;
	logic [BLK_W-1:0]    rk_q;
	logic [BLK_W-1:0]    rk_n;
	logic                last;

	assign rk_n   = key_next(rk_q, rcon(round_q));
	assign last   = (round_q == LAST_ROUND);
	assign busy   = busy_q || done_q;
	assign done   = done_q;
	assign result = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= busy_q && last && !abort;
			if (abort) begin
				busy_q <= 1'b0;
			end else if (start) begin
				busy_q  <= 1'b1;
				round_q <= ROUND_W'(1);
			end else if (busy_q) begin
				round_q <= round_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !abort) begin
			state_q <= blk ^ key;
			rk_q    <= key;
		end else if (busy_q) begin
			state_q <= aes_round(state_q, rk_n, last);
			rk_q    <= rk_n;
		end
	end

endmodule

/* rtl/core/aesctr_back.sv */
// ----------------------------------------------------------------------------
// aesctr_back
// Executes queued items: holds key, nonce, counter and keystream, drives output.
// ----------------------------------------------------------------------------
module aesctr_back import aesctr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [KEY_HALF_W-1:0] cfg_data,
	input  head_t                 head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte
);

	logic [KEY_HALF_W-1:0] key_high_q;
	logic [KEY_HALF_W-1:0] key_low_q;
	logic [IV_W-1:0]       nonce_q;
	logic [CTR_W-1:0]      ctr_q;
	logic [BLK_W-1:0]      cur_ks_q;
	logic                  cur_valid_q;
	logic [3:0]            pos_q;
	logic [BLK_W-1:0]      nxt_ks_q;
	logic                  nxt_valid_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;

	logic                  restart_go;
	logic                  data_go;
	logic                  abort;
	logic                  start;
	logic                  eng_busy;
	logic                  eng_done;
	logic [BLK_W-1:0]      eng_result;
	logic [BLK_W-1:0]      ks_blk;
	logic [3:0]            sel;
	logic [3:0]            sel_inv;
	logic [7:0]            ks_byte;

	assign restart_go = head.valid && (head.item.kind == KIND_RESTART);
	assign data_go    = head.valid && (head.item.kind == KIND_DATA)
		&& (cur_valid_q || nxt_valid_q) && (!out_valid_q || out_ready);
	assign pop        = restart_go || data_go;
	assign abort      = cfg_we || restart_go;
	assign start      = !eng_busy && !nxt_valid_q && !abort;

	assign ks_blk  = cur_valid_q ? cur_ks_q : nxt_ks_q;
	assign sel     = cur_valid_q ? pos_q : 4'd0;
	assign sel_inv = ~sel;
	assign ks_byte = ks_blk[{sel_inv, 3'b000} +: 8];

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	aesctr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.abort  (abort),
		.key    ({key_high_q, key_low_q}),
		.blk    ({nonce_q, ctr_q}),
		.busy   (eng_busy),
		.done   (eng_done),
		.result (eng_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q  <= '0;
			key_low_q   <= '0;
			nonce_q     <= '0;
			ctr_q       <= '0;
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			nxt_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_KEY_HIGH: key_high_q <= cfg_data;
					REG_KEY_LOW:  key_low_q  <= cfg_data;
					default:      ;
				endcase
			end
			if (restart_go) begin
				nonce_q     <= head.item.iv;
				ctr_q       <= '0;
				pos_q       <= '0;
				cur_valid_q <= 1'b0;
			end else if (data_go) begin
				if (cur_valid_q) begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == 4'hf) begin
						cur_valid_q <= 1'b0;
					end
				end else begin
					cur_valid_q <= 1'b1;
					pos_q       <= 4'd1;
					ctr_q       <= ctr_q + 1'b1;
				end
			end
			// The block computed ahead is dropped on a key write or restart,
			// filled when the engine finishes and emptied when it becomes current.
			if (abort) begin
				nxt_valid_q <= 1'b0;
			end else if (eng_done) begin
				nxt_valid_q <= 1'b1;
			end else if (data_go && !cur_valid_q) begin
				nxt_valid_q <= 1'b0;
			end
			if (data_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (data_go && !cur_valid_q) begin
			cur_ks_q <= nxt_ks_q;
		end
		if (eng_done) begin
			nxt_ks_q <= eng_result;
		end
		if (data_go) begin
			out_byte_q <= head.item.data ^ ks_byte;
		end
	end

endmodule

/* rtl/core/aes128_ctr_byte_stream_cipher_core.sv */
// A data byte is first written into the input queue; its result is registered into out_byte
// when it leaves the queue head with keystream ready and the output register free.
// The first byte after a restart, or the first to need a new block after a key write, waits
// for the AES engine. Throughput: one byte per cycle sustained while out_ready stays high;
// the iterative engine refills the next block while 16 bytes of the current one are consumed.
// Reset (arst_n low, asynchronous): key, nonce and counter clear, queue empties, no keystream.
// ----------------------------------------------------------------------------
// aes128_ctr_byte_stream_cipher_core
// AES-128 counter-mode byte cipher with a queued front end and prefetching back end.
// ----------------------------------------------------------------------------
`include "aes128_ctr_byte_stream_cipher_core_defines.svh"

module aes128_ctr_byte_stream_cipher_core import aesctr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration: index 0 is key_high, index 1 is key_low.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [KEY_HALF_W-1:0] cfg_data,
	// Input items.
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [IV_W-1:0]       iv_value,
	input  logic [7:0]            data_byte,
	// Result bytes.
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte
);

	// The front end only buffers transfers; a restart item flows through the
	// same queue as data so that ordering against data bytes is kept.
	head_t head;
	logic  pop;

	aesctr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.iv_value  (iv_value),
		.data_byte (data_byte),
		.head      (head),
		.pop       (pop)
	);

	// The back end keeps the current keystream block plus one block computed
	// ahead. A key write discards the block computed ahead, while the bytes
	// left in the current block keep the key they were made with. A restart
	// drops both blocks and sets the counter back to zero.
	aesctr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte)
	);

	// The back end never takes an item from an empty queue.
	`AESCTR_ASSERT_SAME(a_pop_nonempty, pop, head.valid, "pop from empty queue")
	// A transfer into the queue leaves at least one item waiting.
	`AESCTR_ASSERT_NEXT(a_push_visible, in_valid && in_ready, head.valid, "accepted item not visible at queue head")

endmodule

/* sim/tb_aes128_ctr_byte_stream_cipher_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aes128_ctr_byte_stream_cipher_core
// Self-checking bench for the AES-128 CTR byte cipher: directed rows, then
// random restart and data streams under several keys, with random idling on
// both channels and one long receiver hold-off. Every result byte is compared
// with a keystream predicted inside the bench.
// ----------------------------------------------------------------------------
module tb_aes128_ctr_byte_stream_cipher_core;
	import aesctr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KEY_HALF_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [IV_W-1:0] iv_value;
	logic [7:0] data_byte;
	logic out_valid;
	logic out_ready;
	logic [7:0] out_byte;

	aes128_ctr_byte_stream_cipher_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .iv_value(iv_value), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte)
	);

	// The bench keeps its own copy of the cipher state.
	logic [63:0] mdl_key_hi, mdl_key_lo, mdl_nonce, mdl_ctr;
	logic [127:0] mdl_stream;
	logic [3:0] mdl_pos;
	logic mdl_have_block;

	logic [7:0] expected_bytes [$];
	int errors = 0;
	int bytes_seen = 0;
	int items_sent = 0;
	int restarts_sent = 0;
	bit hold_started = 0;
	bit hold_off = 0;
	int cycle_count = 0;

	localparam logic [7:0] RC [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
		8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

	function automatic logic [7:0] gf_double(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// Plain AES-128 encryption; byte 0 of the block sits in bits 127..120.
	function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
			input logic [127:0] blk);
		logic [7:0] rk [176];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] w [4];
		logic [7:0] f, a0, a1, a2, a3, x;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) rk[i] = key[127 - 8 * i -: 8];
		for (int i = 4; i < 44; i++) begin
			for (int c = 0; c < 4; c++) w[c] = rk[4 * (i - 1) + c];
			if ((i & 3) == 0) begin
				f = w[0];
				w[0] = SBOX[w[1]] ^ RC[i / 4 - 1];
				w[1] = SBOX[w[2]];
				w[2] = SBOX[w[3]];
				w[3] = SBOX[f];
			end
			for (int c = 0; c < 4; c++) rk[4 * i + c] = rk[4 * (i - 4) + c] ^ w[c];
		end
		for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ rk[i];
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++) t[i + 4 * c] = SBOX[s[i + 4 * ((c + i) & 3)]];
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
					x = a0 ^ a1 ^ a2 ^ a3;
					t[4 * c]     = a0 ^ x ^ gf_double(a0 ^ a1);
					t[4 * c + 1] = a1 ^ x ^ gf_double(a1 ^ a2);
					t[4 * c + 2] = a2 ^ x ^ gf_double(a2 ^ a3);
					t[4 * c + 3] = a3 ^ x ^ gf_double(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16 * r + i];
		end
		for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
		return res;
	endfunction

	// Advance the predicted cipher state by one accepted item. A data byte
	// returns its ciphertext through cipher_out and sets has_byte.
	task automatic predict_cipher(input kind_t k, input logic [63:0] iv,
			input logic [7:0] b, output bit has_byte, output logic [7:0] cipher_out);
		has_byte = 0;
		cipher_out = '0;
		if (k == KIND_RESTART) begin
			mdl_nonce = iv;
			mdl_ctr = '0;
			mdl_pos = '0;
			mdl_have_block = 0;
		end else begin
			// A new block always uses the key held at the moment it is needed.
			if (!mdl_have_block) begin
				mdl_stream = aes_encrypt({mdl_key_hi, mdl_key_lo}, {mdl_nonce, mdl_ctr});
				mdl_ctr = mdl_ctr + 64'd1;
				mdl_pos = '0;
				mdl_have_block = 1;
			end
			cipher_out = b ^ mdl_stream[127 - 8 * mdl_pos -: 8];
			mdl_pos = mdl_pos + 4'd1;
			if (mdl_pos == 4'd0) mdl_have_block = 0;
			has_byte = 1;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		errors++;
		$display("MISMATCH %s: got %02h want %02h (byte %0d)", what, got, want, bytes_seen);
	endtask

	// Clock and the cycle watchdog.
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result checker: compare each transfer on the output with the oldest
	// expected byte.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			bytes_seen++;
			if (expected_bytes.size() == 0)
				report_mismatch("unexpected result", out_byte, 8'h00);
			else if (out_byte !== expected_bytes[0]) begin
				report_mismatch("out_byte", out_byte, expected_bytes[0]);
				void'(expected_bytes.pop_front());
			end else
				void'(expected_bytes.pop_front());
		end
	end

	// Receiver: random stalls per result, plus the long hold-off on request.
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap - 1) @(negedge clk);
				@(negedge clk);
			end
			out_ready <= 1;
			// Keep ready high until a transfer happens, then draw again.
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Send one item, idling first for the number of cycles given in idle.
	task automatic send_item(input kind_t k, input logic [63:0] iv, input logic [7:0] b,
			input int idle);
		bit has_byte;
		logic [7:0] want;
		if (idle > 0) begin
			in_valid <= 0;
			repeat (idle) @(negedge clk);
		end
		in_valid <= 1;
		kind <= k;
		iv_value <= iv;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_cipher(k, iv, b, has_byte, want);
		if (has_byte) expected_bytes.push_back(want);
		else restarts_sent++;
		items_sent++;
		@(negedge clk);
	endtask

	// Key writes are made only with nothing in flight; the extra wait covers
	// a keystream block that may still be computed after a restart.
	task automatic write_key(input cfg_reg_t idx, input logic [63:0] val);
		in_valid <= 0;
		wait (expected_bytes.size() == 0);
		@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == REG_KEY_HIGH) mdl_key_hi = val;
		else mdl_key_lo = val;
	endtask

	function automatic int draw_idle();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
	endfunction

	typedef struct {
		kind_t kind;
		logic [63:0] iv;
		logic [7:0] data;
	} stim_row_t;

	// Directed rows: data before any restart, the field extremes, and restarts with
	// all-zero and all-one IVs.
	stim_row_t directed [10] = '{
		'{KIND_DATA, 64'h0, 8'h00}, '{KIND_DATA, 64'h0, 8'hff},
		'{KIND_DATA, 64'hffff_ffff_ffff_ffff, 8'h5a},
		'{KIND_RESTART, 64'hffff_ffff_ffff_ffff, 8'hff}, '{KIND_DATA, 64'h0, 8'h00},
		'{KIND_DATA, 64'h0, 8'hff}, '{KIND_RESTART, 64'h0, 8'h00},
		'{KIND_DATA, 64'h0, 8'h01}, '{KIND_DATA, 64'h0, 8'h80},
		'{KIND_RESTART, 64'h0123_4567_89ab_cdef, 8'h00}
	};

	initial begin
		int n_rand;
		logic [63:0] k_hi [4];
		logic [63:0] k_lo [4];
		kind = KIND_DATA;
		iv_value = '0;
		data_byte = '0;
		in_valid = 0;
		cfg_we = 0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = '0;
		mdl_key_hi = '0; mdl_key_lo = '0; mdl_nonce = '0; mdl_ctr = '0;
		mdl_stream = '0; mdl_pos = '0; mdl_have_block = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part under the zero reset key.
		foreach (directed[i])
			send_item(directed[i].kind, directed[i].iv, directed[i].data, draw_idle());
		// A run of 20 bytes crosses a block boundary.
		for (int i = 0; i < 20; i++) send_item(KIND_DATA, '0, i[7:0], 0);

		k_hi = '{64'hffff_ffff_ffff_ffff, 64'h2b7e_1516_28ae_d2a6, 64'h0, 64'h0};
		k_lo = '{64'hffff_ffff_ffff_ffff, 64'habf7_1588_09cf_4f3c, 64'h0, 64'h0};
		k_hi[2] = {$urandom, $urandom}; k_lo[2] = {$urandom, $urandom};
		k_hi[3] = {$urandom, $urandom}; k_lo[3] = {$urandom, $urandom};

		// Random phases, each under its own key. Streams are runs of data, each run
		// sometimes led by a restart; a hold-off on the receiver fills the queue.
		for (int ph = 0; ph < 4; ph++) begin
			write_key(REG_KEY_HIGH, k_hi[ph]);
			write_key(REG_KEY_LOW, k_lo[ph]);
			n_rand = 0;
			while (n_rand < 350) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(KIND_RESTART, {$urandom, $urandom}, 8'($urandom), draw_idle());
					n_rand++;
				end
				for (int j = $urandom_range(1, 40); j > 0; j--) begin
					if (ph == 1 && n_rand >= 100 && !hold_started) begin
						hold_off = 1;
						hold_started = 1;
					end
					send_item(KIND_DATA, {$urandom, $urandom}, 8'($urandom),
						($urandom_range(0, 2) == 0) ? draw_idle() : 0);
					n_rand++;
				end
			end
		end
		in_valid <= 0;

		wait (expected_bytes.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d items (%0d restarts) under 5 keys; checked %0d result bytes.",
			items_sent, restarts_sent, bytes_seen);
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors,
				expected_bytes.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
